// ===== rtl/core/rbm_pkg.sv =====
// Shared widths, codes and constants of the ROM bank mapper.
package rbm_pkg;

  localparam int FUNC_W      = 3;
  localparam int BUS_ADDR_W  = 16;
  localparam int BYTE_W      = 8;
  localparam int ROM_ADDR_W  = 19;
  localparam int MIRROR_W    = 2;
  localparam int PRG_BANK_W  = 6;
  localparam int CHR_BANK_W  = 8;
  localparam int APB_ADDR_W  = 3;
  localparam int APB_DATA_W  = 32;

  localparam int WORK_RAM_BYTES_DEF = 8192;

  localparam logic [FUNC_W-1:0] FUNC_CPU_RD  = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_CPU_WR  = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_PIC_RD  = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_TICK    = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_IRQ_CLR = 3'd4;

  localparam logic [BUS_ADDR_W-1:0] REG_DECODE_MASK = 16'hE001;
  localparam logic [BUS_ADDR_W-1:0] REG_BANK_SEL    = 16'h8000;
  localparam logic [BUS_ADDR_W-1:0] REG_BANK_DATA   = 16'h8001;
  localparam logic [BUS_ADDR_W-1:0] REG_MIRROR      = 16'hA000;
  localparam logic [BUS_ADDR_W-1:0] REG_IRQ_LATCH   = 16'hC000;
  localparam logic [BUS_ADDR_W-1:0] REG_IRQ_RELOAD  = 16'hC001;
  localparam logic [BUS_ADDR_W-1:0] REG_IRQ_DISABLE = 16'hE000;
  localparam logic [BUS_ADDR_W-1:0] REG_IRQ_ENABLE  = 16'hE001;

  localparam logic [MIRROR_W-1:0] MIRROR_HW   = 2'd0;
  localparam logic [MIRROR_W-1:0] MIRROR_VERT = 2'd1;
  localparam logic [MIRROR_W-1:0] MIRROR_HORZ = 2'd2;

  localparam logic [PRG_BANK_W-1:0] PRG_BANKS_RESET = 6'd32;

  // config register word index
  localparam logic CFG_PRG_BANKS = 1'b0;

endpackage

// ===== rtl/core/rbm_if.sv =====
// Request and response word channels of the ROM bank mapper.
interface rbm_req_if;
  import rbm_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [FUNC_W-1:0]     func;
  logic [BUS_ADDR_W-1:0] bus_addr;
  logic [BYTE_W-1:0]     write_data;

  modport source (output valid, func, bus_addr, write_data, input ready);
  modport sink (input valid, func, bus_addr, write_data, output ready);
endinterface

interface rbm_rsp_if;
  import rbm_pkg::*;

  logic                  valid;
  logic                  ready;
  logic                  claimed;
  logic                  to_work_ram;
  logic [ROM_ADDR_W-1:0] rom_addr;
  logic [BYTE_W-1:0]     read_data;
  logic [MIRROR_W-1:0]   mirror_mode;
  logic                  irq_pending;

  modport source (output valid, claimed, to_work_ram, rom_addr, read_data, mirror_mode,
                  irq_pending, input ready);
  modport sink (input valid, claimed, to_work_ram, rom_addr, read_data, mirror_mode,
                irq_pending, output ready);
endinterface

// ===== rtl/core/rom_bank_mapper_with_scanline_irq_core.sv =====
// Cartridge bank mapper with scanline interrupt counter: top level.
// One request word is taken every cycle and its response word appears in an output
// register; a new request is taken whenever that register is empty or being drained.
// Work RAM is a single-port synchronous memory, read at acceptance and presented with
// the response. Bank registers, program and character maps and the IRQ counter sit in
// flops updated at acceptance, program map also at an APB write. The user must write the
// bank count register over APB only while no request is in flight; nothing enforces it.
module rom_bank_mapper_with_scanline_irq_core #(
  parameter int WORK_RAM_BYTES = rbm_pkg::WORK_RAM_BYTES_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  rbm_req_if.sink                         req,
  rbm_rsp_if.source                       rsp,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [rbm_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [rbm_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [rbm_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready
);
  import rbm_pkg::*;

  localparam int RAM_AW = $clog2(WORK_RAM_BYTES);

  typedef logic [3:0][PRG_BANK_W-1:0] prg_map_t;
  typedef logic [7:0][CHR_BANK_W-1:0] chr_map_t;
  typedef logic [7:0][BYTE_W-1:0]     bank_regs_t;

  function automatic prg_map_t build_prg(input bank_regs_t regs, input logic swap,
                                         input logic [PRG_BANK_W-1:0] banks);
    prg_map_t                m;
    logic [PRG_BANK_W-1:0]   second_last;
    logic [PRG_BANK_W-1:0]   last;
    logic [PRG_BANK_W-1:0]   sw;
    second_last = {banks[PRG_BANK_W-2:0] - 1'b1, 1'b0};
    last        = {banks[PRG_BANK_W-2:0] - 1'b1, 1'b1};
    sw          = regs[6][PRG_BANK_W-1:0];
    m[0] = swap ? second_last : sw;
    m[1] = regs[7][PRG_BANK_W-1:0];
    m[2] = swap ? sw : second_last;
    m[3] = last;
    return m;
  endfunction

  function automatic chr_map_t build_chr(input bank_regs_t regs, input logic invert);
    logic [3:0][CHR_BANK_W-1:0] pairs;
    logic [3:0][CHR_BANK_W-1:0] singles;
    pairs[0]   = {regs[0][CHR_BANK_W-1:1], 1'b0};
    pairs[1]   = {regs[0][CHR_BANK_W-1:1], 1'b1};
    pairs[2]   = {regs[1][CHR_BANK_W-1:1], 1'b0};
    pairs[3]   = {regs[1][CHR_BANK_W-1:1], 1'b1};
    singles[0] = regs[2];
    singles[1] = regs[3];
    singles[2] = regs[4];
    singles[3] = regs[5];
    return invert ? {pairs, singles} : {singles, pairs};
  endfunction

  // work RAM
  logic [BYTE_W-1:0] work_ram [WORK_RAM_BYTES];
  logic [BYTE_W-1:0] ram_q;
  logic              ram_we;
  logic              ram_re;
  logic [RAM_AW-1:0] ram_addr;

  // mapper state
  logic [PRG_BANK_W-1:0] prg_banks;
  bank_regs_t            bank_regs, bank_regs_next;
  prg_map_t              prg_map;
  chr_map_t              chr_map;
  logic [2:0]            bank_index, bank_index_next;
  logic                  prg_swap, prg_swap_next;
  logic                  chr_invert, chr_invert_next;
  logic [MIRROR_W-1:0]   mirroring, mirroring_next;
  logic [BYTE_W-1:0]     irq_reload, irq_reload_next;
  logic [BYTE_W-1:0]     irq_count, irq_count_next;
  logic                  irq_enabled, irq_enabled_next;
  logic                  irq_flag, irq_flag_next;
  logic                  bank_wr;

  // response register
  logic                  out_valid;
  logic                  out_claimed;
  logic                  out_to_ram;
  logic [ROM_ADDR_W-1:0] out_rom_addr;
  logic                  out_rd_sel;

  logic                  claimed_c;
  logic                  to_ram_c;
  logic [ROM_ADDR_W-1:0] rom_addr_c;

  logic                  accept;
  logic                  cfg_wr;
  logic [PRG_BANK_W-1:0] prg_banks_next;
  logic                  ram_window;

  assign req.ready  = !out_valid || rsp.ready;
  assign accept     = req.valid && req.ready;
  assign cfg_wr     = psel && penable && pwrite && pready && (paddr[2] == CFG_PRG_BANKS);
  assign pready     = 1'b1;
  assign prdata     = (paddr[2] == CFG_PRG_BANKS) ?
                      {{(APB_DATA_W-PRG_BANK_W){1'b0}}, prg_banks} : '0;
  assign prg_banks_next = cfg_wr ? pwdata[PRG_BANK_W-1:0] : prg_banks;

  assign ram_window = (req.bus_addr[15:13] == 3'b011);
  assign ram_addr   = req.bus_addr[RAM_AW-1:0];
  assign ram_we     = accept && (req.func == FUNC_CPU_WR) && ram_window;
  assign ram_re     = accept && (req.func == FUNC_CPU_RD) && ram_window;

  always_comb begin
    bank_regs_next   = bank_regs;
    bank_index_next  = bank_index;
    prg_swap_next    = prg_swap;
    chr_invert_next  = chr_invert;
    mirroring_next   = mirroring;
    irq_reload_next  = irq_reload;
    irq_count_next   = irq_count;
    irq_enabled_next = irq_enabled;
    irq_flag_next    = irq_flag;
    bank_wr          = 1'b0;
    claimed_c        = 1'b0;
    to_ram_c         = 1'b0;
    rom_addr_c       = '0;
    if (accept) begin
      unique case (req.func)
        FUNC_CPU_RD: begin
          if (req.bus_addr[15]) begin
            claimed_c  = 1'b1;
            rom_addr_c = {prg_map[req.bus_addr[14:13]], req.bus_addr[12:0]};
          end else if (ram_window) begin
            claimed_c = 1'b1;
            to_ram_c  = 1'b1;
          end
        end
        FUNC_CPU_WR: begin
          if (req.bus_addr[15]) begin
            unique case (req.bus_addr & REG_DECODE_MASK)
              REG_BANK_SEL: begin
                bank_index_next = req.write_data[2:0];
                prg_swap_next   = req.write_data[6];
                chr_invert_next = req.write_data[7];
              end
              REG_BANK_DATA: begin
                bank_regs_next[bank_index] = req.write_data;
                bank_wr = 1'b1;
              end
              REG_MIRROR:      mirroring_next = req.write_data[0] ? MIRROR_HORZ : MIRROR_VERT;
              REG_IRQ_LATCH:   irq_reload_next = req.write_data;
              REG_IRQ_RELOAD:  irq_count_next = '0;
              REG_IRQ_DISABLE: begin
                irq_enabled_next = 1'b0;
                irq_flag_next    = 1'b0;
              end
              REG_IRQ_ENABLE:  irq_enabled_next = 1'b1;
              default: ;
            endcase
          end else if (ram_window) begin
            claimed_c = 1'b1;
            to_ram_c  = 1'b1;
          end
        end
        FUNC_PIC_RD: begin
          if (req.bus_addr[15:13] == 3'b000) begin
            claimed_c  = 1'b1;
            rom_addr_c = {1'b0, chr_map[req.bus_addr[12:10]], req.bus_addr[9:0]};
          end
        end
        FUNC_TICK: begin
          if (irq_count == '0) begin
            irq_count_next = irq_reload;
          end else begin
            irq_count_next = irq_count - 1'b1;
            if ((irq_count == BYTE_W'(1)) && irq_enabled) begin
              irq_flag_next = 1'b1;
            end
          end
        end
        FUNC_IRQ_CLR: irq_flag_next = 1'b0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ram_we) begin
      work_ram[ram_addr] <= req.write_data;
    end
    if (ram_re) begin
      ram_q <= work_ram[ram_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prg_banks   <= PRG_BANKS_RESET;
      bank_regs   <= '0;
      prg_map     <= build_prg('0, 1'b0, PRG_BANKS_RESET);
      chr_map     <= '0;
      bank_index  <= '0;
      prg_swap    <= 1'b0;
      chr_invert  <= 1'b0;
      mirroring   <= MIRROR_HW;
      irq_reload  <= '0;
      irq_count   <= '0;
      irq_enabled <= 1'b0;
      irq_flag    <= 1'b0;
      out_valid   <= 1'b0;
      out_rd_sel  <= 1'b0;
    end else begin
      prg_banks   <= prg_banks_next;
      bank_regs   <= bank_regs_next;
      bank_index  <= bank_index_next;
      prg_swap    <= prg_swap_next;
      chr_invert  <= chr_invert_next;
      mirroring   <= mirroring_next;
      irq_reload  <= irq_reload_next;
      irq_count   <= irq_count_next;
      irq_enabled <= irq_enabled_next;
      irq_flag    <= irq_flag_next;
      if (bank_wr || cfg_wr) begin
        prg_map <= build_prg(bank_regs_next, prg_swap, prg_banks_next);
      end
      if (bank_wr) begin
        chr_map <= build_chr(bank_regs_next, chr_invert);
      end
      if (accept) begin
        out_valid  <= 1'b1;
        out_rd_sel <= ram_re;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_claimed  <= claimed_c;
      out_to_ram   <= to_ram_c;
      out_rom_addr <= rom_addr_c;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.claimed     = out_claimed;
  assign rsp.to_work_ram = out_to_ram;
  assign rsp.rom_addr    = out_rom_addr;
  assign rsp.read_data   = out_rd_sel ? ram_q : '0;
  assign rsp.mirror_mode = mirroring;
  assign rsp.irq_pending = irq_flag;

endmodule

// ===== dv/rom_bank_mapper_with_scanline_irq_core_tb.sv =====
// Testbench of the ROM bank mapper core: directed and random bus words checked by a predictor.
module rom_bank_mapper_with_scanline_irq_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rbm_pkg::*;

  localparam logic [BUS_ADDR_W-1:0] WRAM_BASE       = 16'h6000;
  localparam logic [BUS_ADDR_W-1:0] ROM_BASE        = 16'h8000;
  localparam logic [BUS_ADDR_W-1:0] CHR_TOP         = 16'h1FFF;
  localparam logic [BUS_ADDR_W-1:0] REG_RAM_PROTECT = 16'hA001;
  localparam logic [BYTE_W-1:0]     CHR_PAIR_MASK   = 8'hFE;
  localparam logic [FUNC_W-1:0]     FUNC_UNUSED_HI  = 3'd7;
  localparam int WRAM_BYTES    = WORK_RAM_BYTES_DEF;
  localparam int IDLE_LIMIT    = 2000;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 80;
  localparam int PRINT_LIMIT   = 40;

  typedef struct packed {
    logic                  claimed;
    logic                  to_work_ram;
    logic [ROM_ADDR_W-1:0] rom_addr;
    logic [BYTE_W-1:0]     read_data;
    logic [MIRROR_W-1:0]   mirror_mode;
    logic                  irq_pending;
  } rsp_word_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  rbm_req_if req_if ();
  rbm_rsp_if rsp_if ();

  rom_bank_mapper_with_scanline_irq_core dut (
    .clk     (clk),
    .rst     (rst),
    .req     (req_if),
    .rsp     (rsp_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #6 clk = ~clk;

  // mapper state as the block should hold it
  logic [PRG_BANK_W-1:0] prg_banks;
  logic [BYTE_W-1:0]     wram [WRAM_BYTES];
  bit                    wram_known [WRAM_BYTES];
  logic [12:0]           wram_used [$];
  logic [BYTE_W-1:0]     bank_reg [8];
  logic [PRG_BANK_W-1:0] prg_map [4];
  logic [CHR_BANK_W-1:0] chr_map [8];
  logic [2:0]            bank_sel;
  logic                  prg_swap;
  logic                  chr_inv;
  logic [MIRROR_W-1:0]   mirror;
  logic [BYTE_W-1:0]     irq_reload_val;
  logic [BYTE_W-1:0]     irq_count;
  logic                  irq_en;
  logic                  irq_flag;

  rsp_word_t   expected_words [$];
  rsp_word_t   next_word;
  int          mismatches = 0;
  int          words_sent = 0;
  int          idle_cycles = 0;
  int unsigned src_idle_pct;
  int unsigned rsp_stall_pct;
  int unsigned rsp_hold_cycles;

  function automatic void rebuild_prg_map();
    logic [PRG_BANK_W-1:0] second_last;
    logic [PRG_BANK_W-1:0] last_bank;
    second_last = {prg_banks[4:0], 1'b0} - 6'd2;
    last_bank   = {prg_banks[4:0], 1'b0} - 6'd1;
    prg_map[0] = prg_swap ? second_last : bank_reg[6][5:0];
    prg_map[1] = bank_reg[7][5:0];
    prg_map[2] = prg_swap ? bank_reg[6][5:0] : second_last;
    prg_map[3] = last_bank;
  endfunction

  function automatic void rebuild_chr_map();
    logic [2:0]        lo;
    logic [2:0]        hi;
    logic [BYTE_W-1:0] r0;
    logic [BYTE_W-1:0] r1;
    lo = chr_inv ? 3'd4 : 3'd0;
    hi = chr_inv ? 3'd0 : 3'd4;
    r0 = bank_reg[0] & CHR_PAIR_MASK;
    r1 = bank_reg[1] & CHR_PAIR_MASK;
    chr_map[lo]        = r0;
    chr_map[lo + 3'd1] = r0 + 8'd1;
    chr_map[lo + 3'd2] = r1;
    chr_map[lo + 3'd3] = r1 + 8'd1;
    for (int i = 0; i < 4; i++) chr_map[hi + 3'(i)] = bank_reg[2 + i];
  endfunction

  function automatic void reset_map_state();
    prg_banks = PRG_BANKS_RESET;
    foreach (wram_known[i]) wram_known[i] = 1'b0;
    wram_used.delete();
    foreach (bank_reg[i]) bank_reg[i] = '0;
    foreach (chr_map[i]) chr_map[i] = '0;
    bank_sel       = '0;
    prg_swap       = 1'b0;
    chr_inv        = 1'b0;
    mirror         = MIRROR_HW;
    irq_reload_val = '0;
    irq_count      = '0;
    irq_en         = 1'b0;
    irq_flag       = 1'b0;
    rebuild_prg_map();
  endfunction

  function automatic void write_mapper_reg(input logic [BUS_ADDR_W-1:0] a,
                                           input logic [BYTE_W-1:0] d);
    case (a & REG_DECODE_MASK)
      REG_BANK_SEL: begin
        bank_sel = d[2:0];
        prg_swap = d[6];
        chr_inv  = d[7];
      end
      REG_BANK_DATA: begin
        bank_reg[bank_sel] = d;
        rebuild_chr_map();
        rebuild_prg_map();
      end
      REG_MIRROR:      mirror = d[0] ? MIRROR_HORZ : MIRROR_VERT;
      REG_IRQ_LATCH:   irq_reload_val = d;
      REG_IRQ_RELOAD:  irq_count = '0;
      REG_IRQ_DISABLE: begin
        irq_en   = 1'b0;
        irq_flag = 1'b0;
      end
      REG_IRQ_ENABLE:  irq_en = 1'b1;
      default: ;
    endcase
  endfunction

  // advances the mapper state by one bus word and returns the word it answers with
  function automatic rsp_word_t map_bus_word(input logic [FUNC_W-1:0] f,
                                             input logic [BUS_ADDR_W-1:0] a,
                                             input logic [BYTE_W-1:0] d);
    rsp_word_t r;
    r = '0;
    case (f)
      FUNC_CPU_RD: begin
        if (a >= ROM_BASE) begin
          r.claimed  = 1'b1;
          r.rom_addr = {prg_map[a[14:13]], a[12:0]};
        end else if (a >= WRAM_BASE) begin
          r.claimed     = 1'b1;
          r.to_work_ram = 1'b1;
          r.read_data   = wram[a[12:0]];
        end
      end
      FUNC_CPU_WR: begin
        if (a >= ROM_BASE) begin
          write_mapper_reg(a, d);
        end else if (a >= WRAM_BASE) begin
          r.claimed     = 1'b1;
          r.to_work_ram = 1'b1;
          wram[a[12:0]] = d;
          if (!wram_known[a[12:0]]) begin
            wram_known[a[12:0]] = 1'b1;
            wram_used.insert(wram_used.size(), a[12:0]);
          end
        end
      end
      FUNC_PIC_RD: begin
        if (a <= CHR_TOP) begin
          r.claimed  = 1'b1;
          r.rom_addr = ROM_ADDR_W'({chr_map[a[12:10]], a[9:0]});
        end
      end
      FUNC_TICK: begin
        if (irq_count == '0) begin
          irq_count = irq_reload_val;
        end else begin
          irq_count = irq_count - 8'd1;
          if (irq_count == '0 && irq_en) irq_flag = 1'b1;
        end
      end
      FUNC_IRQ_CLR: irq_flag = 1'b0;
      default: ;
    endcase
    r.mirror_mode = mirror;
    r.irq_pending = irq_flag;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    mismatches++;
    if (mismatches <= PRINT_LIMIT)
      $display("%0t ERROR %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
  endtask

  // response checker
  always @(posedge clk) begin
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      if (expected_words.size() == 0) begin
        report_mismatch("response word with none pending", 1, 0);
      end else begin
        next_word = expected_words.pop_front();
        if (rsp_if.claimed !== next_word.claimed)
          report_mismatch("claimed", rsp_if.claimed, next_word.claimed);
        if (rsp_if.to_work_ram !== next_word.to_work_ram)
          report_mismatch("to_work_ram", rsp_if.to_work_ram, next_word.to_work_ram);
        if (rsp_if.rom_addr !== next_word.rom_addr)
          report_mismatch("rom_addr", rsp_if.rom_addr, next_word.rom_addr);
        if (rsp_if.read_data !== next_word.read_data)
          report_mismatch("read_data", rsp_if.read_data, next_word.read_data);
        if (rsp_if.mirror_mode !== next_word.mirror_mode)
          report_mismatch("mirror_mode", rsp_if.mirror_mode, next_word.mirror_mode);
        if (rsp_if.irq_pending !== next_word.irq_pending)
          report_mismatch("irq_pending", rsp_if.irq_pending, next_word.irq_pending);
      end
    end
  end

  // watchdog on cycles with no word moving
  always @(posedge clk) begin
    if (rst || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // response side: random stalls, plus a long hold when asked
  initial begin
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rsp_hold_cycles > 0) begin
        rsp_if.ready <= 1'b0;
        rsp_hold_cycles--;
      end else begin
        rsp_if.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
    end
  end

  // offers one word, returns at the edge that accepts it; valid stays up for the next word
  task automatic send_word(input logic [FUNC_W-1:0] f, input logic [BUS_ADDR_W-1:0] a,
                           input logic [BYTE_W-1:0] d);
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      req_if.valid <= 1'b0;
      @(negedge clk);
    end
    req_if.valid      <= 1'b1;
    req_if.func       <= f;
    req_if.bus_addr   <= a;
    req_if.write_data <= d;
    do @(posedge clk); while (!req_if.ready);
    expected_words.insert(expected_words.size(), map_bus_word(f, a, d));
    words_sent++;
  endtask

  // never reads a work RAM byte that has not been written
  task automatic cpu_read(input logic [BUS_ADDR_W-1:0] a);
    if (a >= WRAM_BASE && a < ROM_BASE && !wram_known[a[12:0]]) begin
      if (wram_used.size() == 0) begin
        send_word(FUNC_CPU_WR, a, 8'($urandom));
        return;
      end
      a = {3'b011, wram_used[$urandom_range(wram_used.size() - 1)]};
    end
    send_word(FUNC_CPU_RD, a, 8'($urandom));
  endtask

  task automatic drain_words();
    @(negedge clk);
    req_if.valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_bank_count(input logic [PRG_BANK_W-1:0] n);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {CFG_PRG_BANKS, 2'b00};
    pwdata  <= APB_DATA_W'(n);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    prg_banks = n;
    rebuild_prg_map();
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== APB_DATA_W'(n)) report_mismatch("bank count readback", prdata, n);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic random_sequence();
    int                    kind;
    int                    n;
    logic [FUNC_W-1:0]     f;
    logic [BUS_ADDR_W-1:0] a;
    kind = $urandom_range(99);
    if (kind < 20) begin
      // bank select then bank data, then look through the new maps
      send_word(FUNC_CPU_WR, {3'b100, 12'($urandom), 1'b0}, 8'($urandom));
      send_word(FUNC_CPU_WR, {3'b100, 12'($urandom), 1'b1}, 8'($urandom));
      n = $urandom_range(1, 3);
      repeat (n) begin
        if ($urandom_range(1)) cpu_read({1'b1, 15'($urandom)});
        else send_word(FUNC_PIC_RD, {3'b000, 13'($urandom)}, 8'($urandom));
      end
    end else if (kind < 40) begin
      cpu_read(($urandom_range(2) != 0) ? {1'b1, 15'($urandom)} : 16'($urandom));
    end else if (kind < 55) begin
      a = ($urandom_range(4) != 0) ? {3'b000, 13'($urandom)} : 16'($urandom);
      send_word(FUNC_PIC_RD, a, 8'($urandom));
    end else if (kind < 70) begin
      n = $urandom_range(1, 3);
      repeat (n) send_word(FUNC_CPU_WR, {3'b011, 13'($urandom)}, 8'($urandom));
      n = $urandom_range(1, 3);
      repeat (n) cpu_read({3'b011, 13'($urandom)});
    end else if (kind < 82) begin
      // scanline counter: latch, maybe reload, enable or disable, ticks, maybe clear
      send_word(FUNC_CPU_WR, {3'b110, 12'($urandom), 1'b0},
                ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(5)));
      if ($urandom_range(1)) send_word(FUNC_CPU_WR, {3'b110, 12'($urandom), 1'b1}, 8'($urandom));
      send_word(FUNC_CPU_WR, {3'b111, 12'($urandom), 1'($urandom_range(3) != 0)}, 8'($urandom));
      n = $urandom_range(1, 10);
      repeat (n) send_word(FUNC_TICK, 16'($urandom), 8'($urandom));
      if ($urandom_range(1)) send_word(FUNC_IRQ_CLR, 16'($urandom), 8'($urandom));
    end else if (kind < 92) begin
      send_word(FUNC_CPU_WR, {1'b1, 15'($urandom)}, 8'($urandom));
    end else begin
      f = 3'($urandom_range(7));
      a = 16'($urandom);
      if (f == FUNC_CPU_RD) cpu_read(a);
      else send_word(f, a, 8'($urandom));
    end
  endtask

  task automatic test_reset_maps();
    cpu_read(ROM_BASE);
    cpu_read(16'hFFFF);
    send_word(FUNC_PIC_RD, CHR_TOP, 8'h00);
    send_word(FUNC_PIC_RD, CHR_TOP + 16'd1, 8'hFF);
    cpu_read(WRAM_BASE - 16'd1);
    send_word(FUNC_CPU_WR, WRAM_BASE - 16'd1, 8'hFF);
  endtask

  task automatic test_work_ram();
    send_word(FUNC_CPU_WR, WRAM_BASE, 8'hFF);
    send_word(FUNC_CPU_WR, ROM_BASE - 16'd1, 8'h00);
    cpu_read(WRAM_BASE);
    cpu_read(ROM_BASE - 16'd1);
  endtask

  task automatic test_bank_registers();
    // swap and invert on, bank 6
    send_word(FUNC_CPU_WR, REG_BANK_SEL, 8'hC6);
    send_word(FUNC_CPU_WR, REG_BANK_DATA, 8'hFF);
    cpu_read(16'hC000);
    send_word(FUNC_PIC_RD, 16'h1000, 8'h00);
    send_word(FUNC_CPU_WR, REG_MIRROR, 8'h01);
    send_word(FUNC_CPU_WR, REG_RAM_PROTECT, 8'hFF);
  endtask

  task automatic test_scanline_irq();
    send_word(FUNC_CPU_WR, REG_IRQ_LATCH, 8'd2);
    send_word(FUNC_CPU_WR, REG_IRQ_RELOAD, 8'h00);
    send_word(FUNC_CPU_WR, REG_IRQ_ENABLE, 8'h00);
    repeat (3) send_word(FUNC_TICK, 16'h0000, 8'h00);
    send_word(FUNC_IRQ_CLR, 16'h0000, 8'h00);
  endtask

  task automatic test_unused_funcs();
    send_word(FUNC_UNUSED_HI, 16'hFFFF, 8'hFF);
    drain_words();
  endtask

  task automatic test_random_traffic(input int unsigned src_pct, input int unsigned stall_pct,
                                     input int words);
    int stop_at;
    @(posedge clk);
    src_idle_pct  = src_pct;
    rsp_stall_pct = stall_pct;
    stop_at = words_sent + words;
    while (words_sent < stop_at) random_sequence();
    drain_words();
  endtask

  task automatic test_backpressure();
    int stop_at;
    @(posedge clk);
    src_idle_pct    = 0;
    rsp_stall_pct   = 0;
    rsp_hold_cycles = HOLD_CYCLES;
    stop_at = words_sent + 100;
    while (words_sent < stop_at) random_sequence();
    drain_words();
  endtask

  initial begin
    rst                = 1'b1;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    req_if.valid       = 1'b0;
    req_if.func        = '0;
    req_if.bus_addr    = '0;
    req_if.write_data  = '0;
    src_idle_pct       = 0;
    rsp_stall_pct      = 0;
    rsp_hold_cycles    = 0;
    reset_map_state();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_maps();
    test_work_ram();
    test_bank_registers();
    test_scanline_irq();
    test_unused_funcs();

    test_random_traffic(0, 0, 200);
    set_bank_count(6'd1);
    test_random_traffic(51, 0, 200);
    set_bank_count(6'd63);
    test_random_traffic(0, 51, 200);
    set_bank_count(6'd0);
    test_random_traffic(10, 10, 200);
    set_bank_count(6'($urandom_range(2, 31)));
    test_backpressure();
    set_bank_count(PRG_BANKS_RESET);
    test_random_traffic(0, 0, 100);

    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
